[rtl/wes_pkg.sv]
// wes_pkg: shared widths, register codes, reset values and ring entry type
// for the window energy sum trigger. No dependencies.
package wes_pkg;

  localparam int TIME_W      = 32;
  localparam int ENERGY_W    = 24;
  localparam int WINLEN_W    = 31;
  localparam int THRESH_W    = 32;
  localparam int OFFSET_W    = 32;
  localparam int DEAD_W      = 31;
  localparam int CFG_DATA_W  = 32;
  localparam int CFG_INDEX_W = 2;

  localparam int WINDOW_DEPTH_DEFAULT = 64;

  localparam logic [WINLEN_W-1:0] WINDOW_LENGTH_RESET = WINLEN_W'(1000);

  localparam logic signed [TIME_W-1:0] TIME_MAX = {1'b0, {(TIME_W-1){1'b1}}};
  localparam logic signed [TIME_W-1:0] TIME_MIN = {1'b1, {(TIME_W-1){1'b0}}};

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_WINDOW_LENGTH    = 2'd0,
    REG_ENERGY_THRESHOLD = 2'd1,
    REG_TRIGGER_OFFSET   = 2'd2,
    REG_DEAD_TIME        = 2'd3
  } cfg_index_t;

  typedef struct packed {
    logic signed [TIME_W-1:0] hit_time;
    logic [ENERGY_W-1:0]      hit_energy;
  } ring_entry_t;

endpackage

[rtl/window_energy_sum_trigger.sv]
// Window energy sum trigger: hit ring in one synchronous memory, a sequencer
// that evicts expired hits, checks the threshold and stores the new hit.
// Depends on wes_pkg.
//
// Sequence: IDLE takes the input beat, SCAN evicts expired hits, COMMIT stores
// the hit, EMIT loads the result beat; a dead hit skips the store and goes from
// SCAN to EMIT. A stalled result beat holds EMIT. A new hit is taken only in
// IDLE; the single ring read port gives one eviction check per cycle.
// Reset (rst, synchronous): clears the sequencer, ring pointers, window sum,
// dead-until and config to defaults; ring contents stay undefined (no sweep).
module window_energy_sum_trigger #(
  parameter int WINDOW_DEPTH = wes_pkg::WINDOW_DEPTH_DEFAULT
) (
  input  logic                                        clk,
  input  logic                                        rst,
  input  logic                                        cfg_write,
  input  wes_pkg::cfg_index_t                         cfg_index,
  input  logic [wes_pkg::CFG_DATA_W-1:0]              cfg_data,
  input  logic                                        in_valid,
  output logic                                        in_stall,
  input  logic signed [wes_pkg::TIME_W-1:0]           hit_time,
  input  logic [wes_pkg::ENERGY_W-1:0]                hit_energy,
  input  logic                                        first_of_event,
  output logic                                        out_valid,
  input  logic                                        out_stall,
  output logic                                        trigger_fired,
  output logic signed [wes_pkg::TIME_W-1:0]           trigger_time,
  output logic                                        window_overflow
);
  import wes_pkg::*;

  localparam int PTR_W  = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int CNT_W  = $clog2(WINDOW_DEPTH + 1);
  localparam int SUM_W  = ENERGY_W + CNT_W;
  localparam int CMP_W  = (SUM_W > THRESH_W) ? SUM_W : THRESH_W;
  localparam int SLOT_W = CNT_W + 1;

  typedef enum logic [1:0] {IDLE, SCAN, COMMIT, EMIT} state_t;

  // config
  logic [WINLEN_W-1:0]        window_length;
  logic [THRESH_W-1:0]        energy_threshold;
  logic signed [OFFSET_W-1:0] trigger_offset;
  logic [DEAD_W-1:0]          dead_time;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_length    <= WINDOW_LENGTH_RESET;
      energy_threshold <= '0;
      trigger_offset   <= '0;
      dead_time        <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_WINDOW_LENGTH:    window_length    <= cfg_data[WINLEN_W-1:0];
        REG_ENERGY_THRESHOLD: energy_threshold <= cfg_data[THRESH_W-1:0];
        REG_TRIGGER_OFFSET:   trigger_offset   <= $signed(cfg_data[OFFSET_W-1:0]);
        REG_DEAD_TIME:        dead_time        <= cfg_data[DEAD_W-1:0];
        default: ;
      endcase
    end
  end

  // control and window state
  state_t                   state, state_next;
  logic [PTR_W-1:0]         ring_head, ring_head_next;
  logic [CNT_W-1:0]         ring_count, ring_count_next;
  logic [SUM_W-1:0]         window_sum, window_sum_next;
  logic signed [TIME_W-1:0] dead_until, dead_until_next;

  // current hit
  logic signed [TIME_W-1:0] cur_time;
  logic [ENERGY_W-1:0]      cur_energy;

  // pending result
  logic                     res_fired, res_fired_next;
  logic signed [TIME_W-1:0] res_time, res_time_next;
  logic                     res_overflow, res_overflow_next;
  logic                     res_load;

  // ring memory
  ring_entry_t              ring_mem [WINDOW_DEPTH];
  ring_entry_t              rd_entry;
  ring_entry_t              wr_entry;
  logic                     mem_we;
  logic [PTR_W-1:0]         mem_waddr;

  logic                     is_dead;
  logic signed [TIME_W:0]   age;
  logic                     expired;
  logic                     ring_full;
  logic                     fire;
  logic [PTR_W-1:0]         head_inc;
  logic [SLOT_W-1:0]        slot_wide;
  logic [PTR_W-1:0]         slot;
  logic signed [TIME_W:0]   ttime_wide;
  logic signed [TIME_W:0]   dead_wide;
  logic signed [TIME_W-1:0] ttime_sat;
  logic signed [TIME_W-1:0] dead_sat;
  logic [SUM_W-1:0]         sum_after_drop;
  logic                     out_free;

  assign in_stall = (state != IDLE);
  assign out_free = !out_valid || !out_stall;

  assign is_dead   = cur_time < dead_until;
  assign age       = {cur_time[TIME_W-1], cur_time} -
                     {rd_entry.hit_time[TIME_W-1], rd_entry.hit_time};
  assign expired   = age > $signed({2'b00, window_length});
  assign ring_full = ring_count == CNT_W'(WINDOW_DEPTH);
  assign fire      = CMP_W'(window_sum) > CMP_W'(energy_threshold);
  assign head_inc  = (ring_head == PTR_W'(WINDOW_DEPTH - 1)) ? '0 : ring_head + 1'b1;

  // full ring writes over the oldest slot, which is the head
  assign slot_wide = SLOT_W'(ring_head) + SLOT_W'(ring_count);
  assign slot      = (slot_wide >= SLOT_W'(WINDOW_DEPTH)) ?
                     PTR_W'(slot_wide - SLOT_W'(WINDOW_DEPTH)) : PTR_W'(slot_wide);

  assign ttime_wide = {cur_time[TIME_W-1], cur_time} +
                      {trigger_offset[OFFSET_W-1], trigger_offset};
  assign dead_wide  = {cur_time[TIME_W-1], cur_time} + $signed({2'b00, dead_time});
  assign ttime_sat  = (ttime_wide[TIME_W] != ttime_wide[TIME_W-1]) ?
                      (ttime_wide[TIME_W] ? TIME_MIN : TIME_MAX) : ttime_wide[TIME_W-1:0];
  assign dead_sat   = (dead_wide[TIME_W] != dead_wide[TIME_W-1]) ?
                      (dead_wide[TIME_W] ? TIME_MIN : TIME_MAX) : dead_wide[TIME_W-1:0];

  assign sum_after_drop = window_sum - (ring_full ? SUM_W'(rd_entry.hit_energy) : '0);

  assign wr_entry  = {cur_time, cur_energy};
  assign mem_waddr = slot;

  always_comb begin
    state_next        = state;
    ring_head_next    = ring_head;
    ring_count_next   = ring_count;
    window_sum_next   = window_sum;
    dead_until_next   = dead_until;
    res_fired_next    = res_fired;
    res_time_next     = res_time;
    res_overflow_next = res_overflow;
    res_load          = 1'b0;
    mem_we            = 1'b0;
    unique case (state)
      IDLE: begin
        if (in_valid) begin
          state_next = SCAN;
          if (first_of_event) begin
            ring_head_next  = '0;
            ring_count_next = '0;
            window_sum_next = '0;
            dead_until_next = '0;
          end
        end
      end
      SCAN: begin
        if (is_dead) begin
          ring_head_next    = '0;
          ring_count_next   = '0;
          window_sum_next   = '0;
          res_fired_next    = 1'b0;
          res_time_next     = '0;
          res_overflow_next = 1'b0;
          state_next        = EMIT;
        end else if (ring_count != '0 && expired) begin
          window_sum_next = window_sum - SUM_W'(rd_entry.hit_energy);
          ring_head_next  = head_inc;
          ring_count_next = ring_count - 1'b1;
        end else begin
          state_next = COMMIT;
        end
      end
      COMMIT: begin
        mem_we            = 1'b1;
        res_fired_next    = fire;
        res_time_next     = fire ? ttime_sat : '0;
        res_overflow_next = ring_full;
        if (fire) begin
          dead_until_next = dead_sat;
        end
        window_sum_next = sum_after_drop + SUM_W'(cur_energy);
        if (ring_full) begin
          ring_head_next = head_inc;
        end else begin
          ring_count_next = ring_count + 1'b1;
        end
        state_next = EMIT;
      end
      EMIT: begin
        if (out_free) begin
          res_load   = 1'b1;
          state_next = IDLE;
        end
      end
      default: state_next = IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= IDLE;
      ring_head  <= '0;
      ring_count <= '0;
      window_sum <= '0;
      dead_until <= '0;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      ring_head  <= ring_head_next;
      ring_count <= ring_count_next;
      window_sum <= window_sum_next;
      dead_until <= dead_until_next;
      if (res_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == IDLE && in_valid) begin
      cur_time   <= hit_time;
      cur_energy <= hit_energy;
    end
    res_fired    <= res_fired_next;
    res_time     <= res_time_next;
    res_overflow <= res_overflow_next;
    if (res_load) begin
      trigger_fired   <= res_fired;
      trigger_time    <= res_time;
      window_overflow <= res_overflow;
    end
  end

  // read port follows the next head so rd_entry holds the current head;
  // a write to that entry in the same cycle is forwarded
  always_ff @(posedge clk) begin
    if (mem_we) begin
      ring_mem[mem_waddr] <= wr_entry;
    end
    if (mem_we && mem_waddr == ring_head_next) begin
      rd_entry <= wr_entry;
    end else begin
      rd_entry <= ring_mem[ring_head_next];
    end
  end

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    ring_count <= CNT_W'(WINDOW_DEPTH))
    else $error("ring count above depth");

  a_head_bound: assert property (@(posedge clk) disable iff (rst)
    ring_head <= PTR_W'(WINDOW_DEPTH - 1))
    else $error("ring head out of range");

  a_empty_sum: assert property (@(posedge clk) disable iff (rst)
    ring_count == '0 |-> window_sum == '0)
    else $error("empty ring with nonzero sum");

  a_out_from_emit: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == EMIT)
    else $error("result beat without sequencer emit");

  a_quiet_time: assert property (@(posedge clk) disable iff (rst)
    out_valid && !trigger_fired |-> trigger_time == '0)
    else $error("trigger time nonzero without trigger");
`endif

endmodule
